FILE: design/cop_pkg.sv
`timescale 1ns / 1ps
package cop_pkg;

    localparam int CORDIC_ITERATIONS = 20;

    localparam int TRIG_W = 34;
    localparam int PHASE_W = 32;
    localparam int TIME_W = 40;
    localparam int RATE_W = 48;
    localparam int RADIUS_W = 27;
    localparam int TRIG_REG_W = 18;
    localparam int POS_W = 28;
    localparam int VEL_W = 19;
    localparam int WIDE_POS_W = 42;
    localparam int OMEGA_W = 35;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_INDEX_W = 3;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic signed [POS_W-1:0] POS_MAX = 28'sd134217727;
    localparam logic [17:0] VEL_MAX = 18'd262143;
    localparam logic [RATE_W-1:0] EARTH_RATE_RESET = 48'd3266731025;
    localparam logic signed [TRIG_REG_W-1:0] TRIG_ONE = 18'sd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RADIUS = 3'd0,
        REG_ORBIT_RATE = 3'd1,
        REG_INIT_PHASE = 3'd2,
        REG_EARTH_RATE = 3'd3,
        REG_COS_RAAN = 3'd4,
        REG_SIN_RAAN = 3'd5,
        REG_COS_INCL = 3'd6,
        REG_SIN_INCL = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [RATE_W-1:0] orbit_rate;
        logic [PHASE_W-1:0] initial_phase;
        logic [RATE_W-1:0] earth_rate;
        logic signed [TRIG_REG_W-1:0] cos_raan;
        logic signed [TRIG_REG_W-1:0] sin_raan;
        logic signed [TRIG_REG_W-1:0] cos_incl;
        logic signed [TRIG_REG_W-1:0] sin_incl;
    } cfg_t;

    // atan(2^-i) in Q0.32 turns
    function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [4:0] i);
        logic signed [TRIG_W-1:0] v;
        case (i)
            5'd0: v = 34'sd536870912;
            5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;
            5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;
            5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;
            5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;
            5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [WIDE_POS_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v > 42'(POS_MAX))
            r = POS_MAX;
        else if (v < -42'(POS_MAX))
            r = -POS_MAX;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

FILE: design/cop_phase.sv
`timescale 1ns / 1ps
module cop_phase
    import cop_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                vld_in,
    input  logic [TIME_W-1:0]   t,
    input  logic [RATE_W-1:0]   rate,
    input  logic [PHASE_W-1:0]  start,
    output logic                vld_out,
    output logic [PHASE_W-1:0]  phase
);

    logic [43:0] pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [43:0] pp0_next, pp1_next, pp2_next, pp3_next;
    logic [31:0] mid_reg, mid_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [55:0] sum;
    logic [2:0] vld_reg;

    // rate * time split into four 24x20 partial products
    assign pp0_next = 44'(rate[23:0]) * 44'(t[19:0]);
    assign pp1_next = 44'(rate[23:0]) * 44'(t[39:20]);
    assign pp2_next = 44'(rate[47:24]) * 44'(t[19:0]);
    assign pp3_next = 44'(rate[47:24]) * 44'(t[39:20]);

    assign sum = 56'(pp0_reg) + 56'({pp1_reg, 20'd0}) + 56'({pp2_reg, 24'd0})
               + 56'({pp3_reg, 44'd0});
    assign mid_next = sum[55:24];
    assign phase_next = mid_reg + start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp0_reg <= pp0_next;
            pp1_reg <= pp1_next;
            pp2_reg <= pp2_next;
            pp3_reg <= pp3_next;
            mid_reg <= mid_next;
            phase_reg <= phase_next;
        end
    end

    assign vld_out = vld_reg[2];
    assign phase = phase_reg;

endmodule

FILE: design/cop_cordic.sv
`timescale 1ns / 1ps
module cop_cordic
    import cop_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     vld_in,
    input  logic [PHASE_W-1:0]       phase,
    output logic                     vld_out,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    localparam int N = CORDIC_ITERATIONS;

    logic signed [TRIG_W-1:0] x_reg [0:N];
    logic signed [TRIG_W-1:0] y_reg [0:N];
    logic signed [TRIG_W-1:0] z_reg [0:N];
    logic flip_reg [0:N];
    logic [N+1:0] vld_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic flip_next;
    logic [PHASE_W-1:0] folded, quarter;

    // fold the left half-plane around, negate at the end
    assign quarter = phase + 32'h4000_0000;
    assign flip_next = quarter[31];
    assign folded = flip_next ? (phase ^ 32'h8000_0000) : phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= 34'(signed'(folded));
            flip_reg[0] <= flip_next;
            cos_reg <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_iter
        logic signed [TRIG_W-1:0] dx, dy, ang;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign ang = atan_turn(5'(k));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                flip_reg[k+1] <= flip_reg[k];
                if (!z_reg[k][TRIG_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - ang;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + ang;
                end
            end
        end
    end

    assign vld_out = vld_reg[N+1];
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

FILE: design/cop_frame.sv
`timescale 1ns / 1ps
module cop_frame
    import cop_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         vld_in,
    input  cfg_t                         cfg,
    input  logic signed [TRIG_W-1:0]     cv,
    input  logic signed [TRIG_W-1:0]     sv,
    input  logic signed [TRIG_W-1:0]     ce,
    input  logic signed [TRIG_W-1:0]     se,
    output logic                         vld_out,
    output logic signed [WIDE_POS_W-1:0] ex,
    output logic signed [WIDE_POS_W-1:0] ey,
    output logic signed [35:0]           pz,
    output logic [POS_W-1:0]             px_sat,
    output logic [POS_W-1:0]             py_sat,
    output logic [POS_W-1:0]             pz_sat
);

    logic [7:0] vld_reg;
    logic signed [TRIG_W-1:0] ce_d [1:6];
    logic signed [TRIG_W-1:0] se_d [1:6];

    // stage 1
    logic signed [51:0] p_ci_reg, p_uz_reg, p_oc_reg, p_sc_reg;
    // stage 2
    logic signed [51:0] ci_w, uz_w, a_w, b_w;
    logic signed [35:0] ci_reg, uz2_reg, a2_reg, b2_reg;
    // stage 3
    logic signed [53:0] q_s_reg, q_c_reg;
    logic signed [35:0] uz3_reg, a3_reg, b3_reg;
    // stage 4
    logic signed [53:0] q_s_w, q_c_w;
    logic signed [37:0] ux_reg, uy_reg, uz4_reg;
    // stage 5
    logic signed [27:0] r;
    logic signed [65:0] rx_reg, ry_reg, rz_reg;
    // stage 6
    logic signed [65:0] px_w, py_w, pz_w;
    logic signed [35:0] px_reg, py_reg, pz6_reg;
    // stage 7
    logic signed [69:0] m_xc_reg, m_ys_reg, m_yc_reg, m_xs_reg;
    logic signed [35:0] pz7_reg;
    logic [POS_W-1:0] sx7_reg, sy7_reg, sz7_reg;
    // stage 8
    logic signed [69:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [WIDE_POS_W-1:0] ex_reg, ey_reg;
    logic signed [35:0] pz8_reg;
    logic [POS_W-1:0] sx8_reg, sy8_reg, sz8_reg;

    assign ci_w = (p_ci_reg + 52'sd32768) >>> 16;
    assign uz_w = (p_uz_reg + 52'sd32768) >>> 16;
    assign a_w = (p_oc_reg + 52'sd32768) >>> 16;
    assign b_w = (p_sc_reg + 52'sd32768) >>> 16;
    assign q_s_w = (q_s_reg + 54'sd32768) >>> 16;
    assign q_c_w = (q_c_reg + 54'sd32768) >>> 16;
    assign r = signed'({1'b0, cfg.radius});
    assign px_w = (rx_reg + 66'sd536870912) >>> 30;
    assign py_w = (ry_reg + 66'sd536870912) >>> 30;
    assign pz_w = (rz_reg + 66'sd536870912) >>> 30;
    assign r_xc = (m_xc_reg + 70'sd536870912) >>> 30;
    assign r_ys = (m_ys_reg + 70'sd536870912) >>> 30;
    assign r_yc = (m_yc_reg + 70'sd536870912) >>> 30;
    assign r_xs = (m_xs_reg + 70'sd536870912) >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[6:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ce_d[1] <= ce;
            se_d[1] <= se;
            for (int i = 2; i <= 6; i++)
            begin
                ce_d[i] <= ce_d[i-1];
                se_d[i] <= se_d[i-1];
            end

            p_ci_reg <= sv * cfg.cos_incl;
            p_uz_reg <= sv * cfg.sin_incl;
            p_oc_reg <= cv * cfg.cos_raan;
            p_sc_reg <= cv * cfg.sin_raan;

            ci_reg <= ci_w[35:0];
            uz2_reg <= uz_w[35:0];
            a2_reg <= a_w[35:0];
            b2_reg <= b_w[35:0];

            q_s_reg <= ci_reg * cfg.sin_raan;
            q_c_reg <= ci_reg * cfg.cos_raan;
            uz3_reg <= uz2_reg;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;

            ux_reg <= 38'(a3_reg) - 38'(signed'(q_s_w[36:0]));
            uy_reg <= 38'(b3_reg) + 38'(signed'(q_c_w[36:0]));
            uz4_reg <= 38'(uz3_reg);

            rx_reg <= r * ux_reg;
            ry_reg <= r * uy_reg;
            rz_reg <= r * uz4_reg;

            px_reg <= px_w[35:0];
            py_reg <= py_w[35:0];
            pz6_reg <= pz_w[35:0];

            m_xc_reg <= px_reg * ce_d[6];
            m_ys_reg <= py_reg * se_d[6];
            m_yc_reg <= py_reg * ce_d[6];
            m_xs_reg <= px_reg * se_d[6];
            pz7_reg <= pz6_reg;
            sx7_reg <= sat_pos(42'(px_reg));
            sy7_reg <= sat_pos(42'(py_reg));
            sz7_reg <= sat_pos(42'(pz6_reg));

            ex_reg <= 42'(signed'(r_xc[40:0])) + 42'(signed'(r_ys[40:0]));
            ey_reg <= 42'(signed'(r_yc[40:0])) - 42'(signed'(r_xs[40:0]));
            pz8_reg <= pz7_reg;
            sx8_reg <= sx7_reg;
            sy8_reg <= sy7_reg;
            sz8_reg <= sz7_reg;
        end
    end

    assign vld_out = vld_reg[7];
    assign ex = ex_reg;
    assign ey = ey_reg;
    assign pz = pz8_reg;
    assign px_sat = sx8_reg;
    assign py_sat = sy8_reg;
    assign pz_sat = sz8_reg;

endmodule

FILE: design/cop_vel.sv
`timescale 1ns / 1ps
module cop_vel
    import cop_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         vld_in,
    input  cfg_t                         cfg,
    input  logic signed [WIDE_POS_W-1:0] ex,
    input  logic signed [WIDE_POS_W-1:0] ey,
    input  logic signed [35:0]           pz,
    input  logic [POS_W-1:0]             px_sat,
    input  logic [POS_W-1:0]             py_sat,
    input  logic [POS_W-1:0]             pz_sat,
    output logic                         vld_out,
    output logic [POS_W-1:0]             eci_x,
    output logic [POS_W-1:0]             eci_y,
    output logic [POS_W-1:0]             eci_z,
    output logic [POS_W-1:0]             ecef_x,
    output logic [POS_W-1:0]             ecef_y,
    output logic [POS_W-1:0]             ecef_z,
    output logic [VEL_W-1:0]             vel_x,
    output logic [VEL_W-1:0]             vel_y,
    output logic [VEL_W-1:0]             vel_z
);

    // orbit normal and angular rate follow the registers directly
    logic signed [35:0] nxp_reg, nyp_reg;
    logic signed [35:0] nx_w, ny_w;
    logic signed [20:0] nx_reg, ny_reg;
    logic [63:0] omega_prod_reg;
    logic [OMEGA_W-1:0] omega;

    logic [6:0] vld_reg;
    logic [POS_W-1:0] pos_d [1:7][0:4];

    logic signed [63:0] m_reg [0:5];
    logic signed [64:0] c_reg [0:2];
    logic signed [64:0] neg_c [0:2];
    logic [63:0] mag_reg [0:2];
    logic neg_d [3:6][0:2];
    logic [58:0] pl_reg [0:2];
    logic [63:0] ph_reg [0:2];
    logic [74:0] ph_w [0:2];
    logic [59:0] bs_w [0:2];
    logic [35:0] b_reg [0:2];
    logic [63:0] ph5_reg [0:2];
    logic [63:0] t_w [0:2];
    logic [43:0] t_reg [0:2];
    logic [VEL_W-1:0] vel_reg [0:2];

    assign nx_w = (nxp_reg + 36'sd32768) >>> 16;
    assign ny_w = (nyp_reg + 36'sd32768) >>> 16;
    assign omega = omega_prod_reg[63:29];

    always_ff @(posedge clk)
    begin
        nxp_reg <= cfg.sin_incl * cfg.sin_raan;
        nyp_reg <= cfg.sin_incl * cfg.cos_raan;
        nx_reg <= 21'(signed'(nx_w[19:0]));
        ny_reg <= -21'(signed'(ny_w[19:0]));
        omega_prod_reg <= 64'(cfg.orbit_rate[47:16]) * 64'(TWO_PI_Q29);
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        assign neg_c[j] = -c_reg[j];
        assign ph_w[j] = 75'(omega) * 75'(mag_reg[j][63:24]);
        assign bs_w[j] = 60'(pl_reg[j]) + 60'h800_0000_0000;
        assign t_w[j] = ph5_reg[j] + 64'(b_reg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_d[1][0] <= px_sat;
            pos_d[1][1] <= py_sat;
            pos_d[1][2] <= pz_sat;
            pos_d[1][3] <= sat_pos(ex);
            pos_d[1][4] <= sat_pos(ey);
            for (int s = 2; s <= 7; s++)
            begin
                for (int f = 0; f < 5; f++)
                begin
                    pos_d[s][f] <= pos_d[s-1][f];
                end
            end

            // normal cross ecef position
            m_reg[0] <= ny_reg * pz;
            m_reg[1] <= cfg.cos_incl * ey;
            m_reg[2] <= cfg.cos_incl * ex;
            m_reg[3] <= nx_reg * pz;
            m_reg[4] <= nx_reg * ey;
            m_reg[5] <= ny_reg * ex;

            c_reg[0] <= 65'(m_reg[0]) - 65'(m_reg[1]);
            c_reg[1] <= 65'(m_reg[2]) - 65'(m_reg[3]);
            c_reg[2] <= 65'(m_reg[4]) - 65'(m_reg[5]);

            for (int j = 0; j < 3; j++)
            begin
                mag_reg[j] <= c_reg[j][64] ? neg_c[j][63:0] : c_reg[j][63:0];
                neg_d[3][j] <= c_reg[j][64];
                for (int s = 4; s <= 6; s++)
                begin
                    neg_d[s][j] <= neg_d[s-1][j];
                end

                pl_reg[j] <= 59'(omega) * 59'(mag_reg[j][23:0]);
                ph_reg[j] <= ph_w[j][63:0];

                b_reg[j] <= bs_w[j][59:24];
                ph5_reg[j] <= ph_reg[j];

                t_reg[j] <= t_w[j][63:20];

                if (t_reg[j] > 44'(VEL_MAX))
                    vel_reg[j] <= neg_d[6][j] ? -19'(VEL_MAX) : 19'(VEL_MAX);
                else
                    vel_reg[j] <= neg_d[6][j] ? -19'(t_reg[j][17:0]) : 19'(t_reg[j][17:0]);
            end
        end
    end

    assign vld_out = vld_reg[6];
    assign eci_x = pos_d[7][0];
    assign eci_y = pos_d[7][1];
    assign eci_z = pos_d[7][2];
    assign ecef_x = pos_d[7][3];
    assign ecef_y = pos_d[7][4];
    assign ecef_z = pos_d[7][2];
    assign vel_x = vel_reg[0];
    assign vel_y = vel_reg[1];
    assign vel_z = vel_reg[2];

endmodule

FILE: design/circular_orbit_position_unit.sv
`timescale 1ns / 1ps
// channel   signals                          direction
// request   in_valid, in_stall, sim_time     in (in_stall out)
// result    out_valid, out_stall, eci/ecef/vel out (out_stall in)
// config    wr_en, wr_index, wr_data         in
//
// one request per cycle while no held result stalls the pipeline; the path runs
// through the three phase stages, the rotation pipeline, eight frame stages and
// seven velocity stages
// reset clears the valid bits and loads the register defaults
// a held result freezes the whole pipeline; in_stall is high only then
module circular_orbit_position_unit
    import cop_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIME_W-1:0]      sim_time,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [POS_W-1:0] eci_x,
    output logic signed [POS_W-1:0] eci_y,
    output logic signed [POS_W-1:0] eci_z,
    output logic signed [POS_W-1:0] ecef_x,
    output logic signed [POS_W-1:0] ecef_y,
    output logic signed [POS_W-1:0] ecef_z,
    output logic signed [VEL_W-1:0] vel_x,
    output logic signed [VEL_W-1:0] vel_y,
    output logic signed [VEL_W-1:0] vel_z,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t cfg_reg;
    logic adv;
    logic vld_po, vld_pe, vld_co, vld_ce, vld_f;
    logic [PHASE_W-1:0] phase_o, phase_e;
    logic signed [TRIG_W-1:0] cv, sv, ce, se;
    logic signed [WIDE_POS_W-1:0] ex, ey;
    logic signed [35:0] pz;
    logic [POS_W-1:0] px_sat, py_sat, pz_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius <= '0;
            cfg_reg.orbit_rate <= '0;
            cfg_reg.initial_phase <= '0;
            cfg_reg.earth_rate <= EARTH_RATE_RESET;
            cfg_reg.cos_raan <= TRIG_ONE;
            cfg_reg.sin_raan <= '0;
            cfg_reg.cos_incl <= TRIG_ONE;
            cfg_reg.sin_incl <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_RADIUS: cfg_reg.radius <= wr_data[RADIUS_W-1:0];
                REG_ORBIT_RATE: cfg_reg.orbit_rate <= wr_data[RATE_W-1:0];
                REG_INIT_PHASE: cfg_reg.initial_phase <= wr_data[PHASE_W-1:0];
                REG_EARTH_RATE: cfg_reg.earth_rate <= wr_data[RATE_W-1:0];
                REG_COS_RAAN: cfg_reg.cos_raan <= wr_data[TRIG_REG_W-1:0];
                REG_SIN_RAAN: cfg_reg.sin_raan <= wr_data[TRIG_REG_W-1:0];
                REG_COS_INCL: cfg_reg.cos_incl <= wr_data[TRIG_REG_W-1:0];
                REG_SIN_INCL: cfg_reg.sin_incl <= wr_data[TRIG_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    cop_phase u_phase_orbit (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (in_valid),
        .t       (sim_time),
        .rate    (cfg_reg.orbit_rate),
        .start   (cfg_reg.initial_phase),
        .vld_out (vld_po),
        .phase   (phase_o)
    );

    cop_phase u_phase_earth (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (in_valid),
        .t       (sim_time),
        .rate    (cfg_reg.earth_rate),
        .start   ('0),
        .vld_out (vld_pe),
        .phase   (phase_e)
    );

    cop_cordic u_cordic_orbit (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_po),
        .phase   (phase_o),
        .vld_out (vld_co),
        .cos_out (cv),
        .sin_out (sv)
    );

    cop_cordic u_cordic_earth (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_pe),
        .phase   (phase_e),
        .vld_out (vld_ce),
        .cos_out (ce),
        .sin_out (se)
    );

    cop_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_co && vld_ce),
        .cfg     (cfg_reg),
        .cv      (cv),
        .sv      (sv),
        .ce      (ce),
        .se      (se),
        .vld_out (vld_f),
        .ex      (ex),
        .ey      (ey),
        .pz      (pz),
        .px_sat  (px_sat),
        .py_sat  (py_sat),
        .pz_sat  (pz_sat)
    );

    cop_vel u_vel (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_f),
        .cfg     (cfg_reg),
        .ex      (ex),
        .ey      (ey),
        .pz      (pz),
        .px_sat  (px_sat),
        .py_sat  (py_sat),
        .pz_sat  (pz_sat),
        .vld_out (out_valid),
        .eci_x   (eci_x),
        .eci_y   (eci_y),
        .eci_z   (eci_z),
        .ecef_x  (ecef_x),
        .ecef_y  (ecef_y),
        .ecef_z  (ecef_z),
        .vel_x   (vel_x),
        .vel_y   (vel_y),
        .vel_z   (vel_z)
    );

endmodule

FILE: test/tb_circular_orbit_position_unit.sv
`timescale 1ns / 1ps
module tb_circular_orbit_position_unit;
    import cop_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] eci_x;
        logic signed [POS_W-1:0] eci_y;
        logic signed [POS_W-1:0] eci_z;
        logic signed [POS_W-1:0] ecef_x;
        logic signed [POS_W-1:0] ecef_y;
        logic signed [POS_W-1:0] ecef_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
    } orbit_fix_t;

    class orbit_scoreboard;
        orbit_fix_t pending[$];
        int errors = 0;
        int checked = 0;

        function void note(orbit_fix_t r);
            pending.push_back(r);
        endfunction

        function void cmp(string n, longint e, longint a);
            if (e != a)
            begin
                $display("%0t %s expected %0d actual %0d", $time, n, e, a);
                errors++;
            end
        endfunction

        function void check(orbit_fix_t a);
            orbit_fix_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result, expected none actual eci_x %0d",
                         $time, a.eci_x);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            cmp("eci_x", e.eci_x, a.eci_x);
            cmp("eci_y", e.eci_y, a.eci_y);
            cmp("eci_z", e.eci_z, a.eci_z);
            cmp("ecef_x", e.ecef_x, a.ecef_x);
            cmp("ecef_y", e.ecef_y, a.ecef_y);
            cmp("ecef_z", e.ecef_z, a.ecef_z);
            cmp("vel_x", e.vel_x, a.vel_x);
            cmp("vel_y", e.vel_y, a.vel_y);
            cmp("vel_z", e.vel_z, a.vel_z);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    localparam longint ARCTAN_TURNS [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0};

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [TIME_W-1:0] sim_time;
    logic out_valid;
    logic out_stall;
    orbit_fix_t got;
    logic wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    orbit_scoreboard fixes;
    cfg_t regs;
    bit idle_on;
    int hold_req;
    int hold_cnt;
    int stall_left;
    int quiet_cycles;
    int sent;

    circular_orbit_position_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sim_time(sim_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .eci_x(got.eci_x), .eci_y(got.eci_y), .eci_z(got.eci_z),
        .ecef_x(got.ecef_x), .ecef_y(got.ecef_y), .ecef_z(got.ecef_z),
        .vel_x(got.vel_x), .vel_y(got.vel_y), .vel_z(got.vel_z),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint round_mul(longint a, longint b, int sh);
        return (a * b + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [31:0] turn_phase(longint unsigned rate,
                                               longint unsigned t,
                                               logic [31:0] start);
        longint unsigned prod;
        prod = rate * t;
        return prod[55:24] + start;
    endfunction

    function automatic void sin_cos(input logic [31:0] p, output longint c,
                                    output longint s);
        bit flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [31:0] q;
        q = p + 32'h4000_0000;
        flip = q[31];
        if (flip)
            p = p ^ 32'h8000_0000;
        z = longint'($signed(p));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCTAN_TURNS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCTAN_TURNS[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [POS_W-1:0] clamp_metres(longint v);
        if (v > 134217727)
            v = 134217727;
        if (v < -134217727)
            v = -134217727;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [VEL_W-1:0] scale_velocity(longint c, longint unsigned omega);
        longint unsigned mag;
        longint unsigned b;
        longint unsigned tt;
        mag = c < 0 ? longint'(-c) : longint'(c);
        b = (omega * (mag & 64'hFF_FFFF) + (64'd1 << 43)) >> 24;
        tt = (omega * (mag >> 24) + b) >> 20;
        if (tt > 262143)
            tt = 262143;
        if (c < 0)
            tt = -tt;
        return tt[VEL_W-1:0];
    endfunction

    function automatic orbit_fix_t predict_fix(cfg_t c, logic [TIME_W-1:0] t);
        orbit_fix_t r;
        longint co, so, cinc, sinc, rad;
        longint cv, sv, ce, se, ci, ux, uy, uz, px, py, pz, ex, ey, nx, ny;
        longint unsigned omega;
        co = longint'(c.cos_raan);
        so = longint'(c.sin_raan);
        cinc = longint'(c.cos_incl);
        sinc = longint'(c.sin_incl);
        rad = longint'(c.radius);
        sin_cos(turn_phase(c.orbit_rate, t, c.initial_phase), cv, sv);
        sin_cos(turn_phase(c.earth_rate, t, 32'd0), ce, se);
        ci = round_mul(sv, cinc, 16);
        ux = round_mul(co, cv, 16) - round_mul(so, ci, 16);
        uy = round_mul(so, cv, 16) + round_mul(co, ci, 16);
        uz = round_mul(sv, sinc, 16);
        px = round_mul(rad, ux, 30);
        py = round_mul(rad, uy, 30);
        pz = round_mul(rad, uz, 30);
        ex = round_mul(px, ce, 30) + round_mul(py, se, 30);
        ey = round_mul(py, ce, 30) - round_mul(px, se, 30);
        nx = round_mul(sinc, so, 16);
        ny = -round_mul(sinc, co, 16);
        omega = ((longint'(c.orbit_rate) >> 16) * 64'd3373259426) >> 29;
        r.eci_x = clamp_metres(px);
        r.eci_y = clamp_metres(py);
        r.eci_z = clamp_metres(pz);
        r.ecef_x = clamp_metres(ex);
        r.ecef_y = clamp_metres(ey);
        r.ecef_z = clamp_metres(pz);
        r.vel_x = scale_velocity(ny * pz - cinc * ey, omega);
        r.vel_y = scale_velocity(cinc * ex - nx * pz, omega);
        r.vel_z = scale_velocity(nx * ey - ny * ex, omega);
        return r;
    endfunction

    // result side, stall pattern and watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            fixes.check(got);
        if (hold_req)
        begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else if (!idle_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        @(posedge clk);
    endtask

    task automatic load_regs(cfg_t c);
        write_reg(REG_RADIUS, CFG_DATA_W'(c.radius));
        write_reg(REG_ORBIT_RATE, c.orbit_rate);
        write_reg(REG_INIT_PHASE, CFG_DATA_W'(c.initial_phase));
        write_reg(REG_EARTH_RATE, c.earth_rate);
        write_reg(REG_COS_RAAN, CFG_DATA_W'(c.cos_raan) & 48'h3FFFF);
        write_reg(REG_SIN_RAAN, CFG_DATA_W'(c.sin_raan) & 48'h3FFFF);
        write_reg(REG_COS_INCL, CFG_DATA_W'(c.cos_incl) & 48'h3FFFF);
        write_reg(REG_SIN_INCL, CFG_DATA_W'(c.sin_incl) & 48'h3FFFF);
        wr_en <= 1'b0;
        regs = c;
    endtask

    task automatic drain();
        while (fixes.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_time(logic [TIME_W-1:0] t);
        in_valid <= 1'b1;
        sim_time <= t;
        do
            @(posedge clk);
        while (in_stall);
        fixes.note(predict_fix(regs, t));
        sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return TIME_W'(w[23:0]);
            1: return TIME_W'(w[31:0]);
            default: return w[TIME_W-1:0];
        endcase
    endfunction

    function automatic logic signed [TRIG_REG_W-1:0] random_trig(bit wild);
        if (wild)
            return TRIG_REG_W'($urandom);
        return TRIG_REG_W'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic cfg_t random_regs(bit wild);
        cfg_t c;
        c.radius = $urandom_range(0, 3) == 0 ? RADIUS_W'($urandom)
                                             : RADIUS_W'($urandom_range(6000000, 45000000));
        c.orbit_rate = $urandom_range(0, 2) == 0 ? RATE_W'({$urandom, $urandom})
                                                 : RATE_W'({$urandom_range(0, 65535), $urandom});
        c.initial_phase = $urandom;
        c.earth_rate = RATE_W'({$urandom, $urandom});
        c.cos_raan = random_trig(wild);
        c.sin_raan = random_trig(wild);
        c.cos_incl = random_trig(wild);
        c.sin_incl = random_trig(wild);
        return c;
    endfunction

    task automatic run_random(int n);
        for (int k = 0; k < n; k++)
            send_time(random_time());
    endtask

    initial
    begin
        cfg_t c;
        fixes = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        sim_time = '0;
        out_stall = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        idle_on = 1'b1;
        hold_req = 0;
        hold_cnt = 0;
        stall_left = 0;
        quiet_cycles = 0;
        sent = 0;
        regs = '{radius: '0, orbit_rate: '0, initial_phase: '0,
                 earth_rate: EARTH_RATE_RESET, cos_raan: TRIG_ONE, sin_raan: '0,
                 cos_incl: TRIG_ONE, sin_incl: '0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset, radius zero
        send_time('0);
        send_time('1);
        in_valid <= 1'b0;
        drain();

        // low orbit, time extremes and wrap
        c = '{radius: 27'd6771000, orbit_rate: 48'd49867893990, initial_phase: 32'd0,
              earth_rate: EARTH_RATE_RESET, cos_raan: 18'sd46341, sin_raan: 18'sd46341,
              cos_incl: 18'sd33000, sin_incl: 18'sd56617};
        load_regs(c);
        send_time('0);
        send_time(40'd1);
        send_time(40'h80_0000_0000);
        send_time(40'hFF_FFFF_FFFF);
        send_time(40'h00_FFFF_FFFF);
        send_time(40'h55_5555_5555);
        send_time(40'hAA_AAAA_AAAA);
        in_valid <= 1'b0;
        drain();

        // radius, rate and phase registers at their top, trig registers at one or minus one, saturating velocity
        c = '{radius: 27'h7FF_FFFF, orbit_rate: 48'hFFFF_FFFF_FFFF,
              initial_phase: 32'hFFFF_FFFF, earth_rate: 48'hFFFF_FFFF_FFFF,
              cos_raan: 18'sd65536, sin_raan: -18'sd65536,
              cos_incl: -18'sd65536, sin_incl: 18'sd65536};
        load_regs(c);
        send_time(40'd0);
        send_time(40'hFF_FFFF_FFFF);
        send_time(40'd12345);
        in_valid <= 1'b0;
        drain();

        // trig registers past one, positions overflow
        c.cos_raan = 18'sh1FFFF;
        c.sin_raan = 18'sh20000;
        c.cos_incl = 18'sh20000;
        c.sin_incl = 18'sh1FFFF;
        load_regs(c);
        send_time(40'd0);
        send_time(40'd1 << 30);
        send_time(40'h12_3456_789A);
        in_valid <= 1'b0;
        drain();

        // zero radius with a fast orbit
        c.radius = '0;
        load_regs(c);
        send_time(40'd77);
        send_time(40'hFF_FFFF_FFFF);
        in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_on = ph != 7;
            load_regs(random_regs(ph == 2 || ph == 5));
            if (ph == 3)
            begin
                // receiver holds off while requests keep coming
                idle_on = 1'b0;
                hold_req = 1;
                run_random(110);
                idle_on = 1'b1;
                run_random(105);
            end
            else if (ph == 4)
            begin
                run_random(100);
                in_valid <= 1'b0;
                drain();
                run_random(115);
            end
            else
                run_random(215);
            in_valid <= 1'b0;
            drain();
        end

        repeat (60) @(posedge clk);
        $display("%0d requests sent over 13 register settings, %0d results compared",
                 sent, fixes.checked);
        if (fixes.errors == 0 && fixes.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
